[hdl/nsd_pkg.sv]
`timescale 1ns / 1ps
package nsd_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = 13;
    localparam int ACC_CAP = ((MAX_DIM > 255) ? MAX_DIM : 255) + 1;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_MAGIC  = 3'd1;
    localparam logic [2:0] ERR_ZERO   = 3'd2;
    localparam logic [2:0] ERR_MAXVAL = 3'd3;
    localparam logic [2:0] ERR_PIXEL  = 3'd4;
    localparam logic [2:0] ERR_CONV   = 3'd5;
    localparam logic [2:0] ERR_LARGE  = 3'd6;
    localparam logic [2:0] ERR_TRUNC  = 3'd7;

    localparam logic [2:0] FMT_P1 = 3'd1;
    localparam logic [2:0] FMT_P2 = 3'd2;
    localparam logic [2:0] FMT_P3 = 3'd3;
    localparam logic [2:0] FMT_P4 = 3'd4;
    localparam logic [2:0] FMT_P6 = 3'd6;

    localparam logic [1:0] TGT_KEEP = 2'd0;
    localparam logic [1:0] TGT_BAD  = 2'd2;

    typedef enum logic [1:0] {
        KIND_HDR = 2'd0,
        KIND_PIX = 2'd1,
        KIND_ERR = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        PH_MAGIC, PH_MAGIC_DIGIT, PH_MAGIC_END, PH_PRE_W, PH_IN_W, PH_PRE_H,
        PH_IN_H, PH_PRE_M, PH_IN_M, PH_DATA, PH_DATA_NUM, PH_DONE
    } t_phase;

    // One command per input byte that produces results.
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         value;
        logic               bit_mode;
        logic [2:0]         last_idx;
        logic [1:0]         ci;
        logic [1:0]         fch;
        logic [1:0]         och;
        logic               done;
        logic [2:0]         err;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } t_cmd;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic [DIM_W-1:0] acc_step(input logic [DIM_W-1:0] acc,
                                                  input logic [7:0] c);
        logic [DIM_W+3:0] t;
        t = {4'b0, acc} * (DIM_W+4)'(10) + {{DIM_W{1'b0}}, c[3:0]};
        if (t > (DIM_W+4)'(ACC_CAP))
            return DIM_W'(ACC_CAP);
        return t[DIM_W-1:0];
    endfunction

endpackage

[hdl/nsd_front.sv]
`timescale 1ns / 1ps
module nsd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte_value,
    input  logic                i_file_end,
    input  logic                i_q_full,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_wr_data,
    output logic                o_cmd_valid,
    output nsd_pkg::t_cmd       o_cmd
);
    import nsd_pkg::*;

    t_phase             r_phase, n_phase;
    logic [2:0]         r_fmt, n_fmt;
    logic [DIM_W-1:0]   r_width, n_width, r_height, n_height, r_acc, n_acc;
    logic [DIM_W-1:0]   r_col, n_col, r_row, n_row;
    logic [1:0]         r_ci, n_ci;
    logic               r_cmt, n_cmt;
    logic [1:0]         r_tc;

    logic               accept, sp, dg, hash, one_bit, fin;
    logic [1:0]         fch, och;
    logic [DIM_W-1:0]   acc_c, acc_0, fin_val, rem;
    logic               comp_req, pk_req, hdr_req, fail_req;
    logic [7:0]         comp_v;
    logic [2:0]         fail_code;
    logic               ev_err, ev_hdr, ev_pix, ev_bits, ev_done;
    logic [2:0]         ev_code, ev_last;
    logic [7:0]         ev_val;
    logic [1:0]         ev_ci;

    assign accept  = i_valid && !i_q_full;
    assign sp      = is_space(i_byte_value);
    assign dg      = is_digit(i_byte_value);
    assign hash    = (i_byte_value == CH_HASH);
    assign one_bit = (r_fmt == FMT_P1) || (r_fmt == FMT_P4);
    assign fch     = (r_fmt == FMT_P3 || r_fmt == FMT_P6) ? 2'd3 : 2'd1;
    assign och     = (r_tc == TGT_KEEP) ? fch : r_tc;
    assign acc_c   = acc_step(r_acc, i_byte_value);
    assign acc_0   = acc_step('0, i_byte_value);
    assign fin     = (fch == 2'd1) || (r_ci == 2'd2);
    assign rem     = r_width - r_col;

    always_comb begin
        n_phase = r_phase;  n_fmt = r_fmt;  n_width = r_width;  n_height = r_height;
        n_acc = r_acc;  n_col = r_col;  n_row = r_row;  n_ci = r_ci;  n_cmt = r_cmt;
        comp_req = 1'b0;  comp_v = '0;  pk_req = 1'b0;  hdr_req = 1'b0;
        fail_req = 1'b0;  fail_code = ERR_NONE;  fin_val = '0;
        ev_err = 1'b0;  ev_hdr = 1'b0;  ev_pix = 1'b0;  ev_bits = 1'b0;  ev_done = 1'b0;
        ev_code = ERR_NONE;  ev_last = '0;  ev_val = '0;  ev_ci = '0;

        case (r_phase)
            PH_MAGIC: begin
                if (i_byte_value == CH_P) n_phase = PH_MAGIC_DIGIT;
                else if (!sp) begin fail_req = 1'b1; fail_code = ERR_MAGIC; end
            end
            PH_MAGIC_DIGIT: begin
                if (i_byte_value inside {[8'h31:8'h36]}) begin
                    n_fmt   = i_byte_value[2:0];
                    n_phase = PH_MAGIC_END;
                end else begin
                    fail_req = 1'b1; fail_code = ERR_MAGIC;
                end
            end
            PH_MAGIC_END: begin
                if (sp) n_phase = PH_PRE_W;
                else if (hash) begin n_cmt = 1'b1; n_phase = PH_PRE_W; end
                else begin fail_req = 1'b1; fail_code = ERR_MAGIC; end
            end
            PH_PRE_W, PH_PRE_H, PH_PRE_M: begin
                if (r_cmt) begin
                    if (i_byte_value == CH_LF || i_byte_value == CH_CR) n_cmt = 1'b0;
                end else if (sp) begin
                    n_cmt = 1'b0;
                end else if (hash) begin
                    n_cmt = 1'b1;
                end else if (dg) begin
                    n_acc   = acc_0;
                    n_phase = (r_phase == PH_PRE_W) ? PH_IN_W :
                              (r_phase == PH_PRE_H) ? PH_IN_H : PH_IN_M;
                end else begin
                    fail_req  = 1'b1;
                    fail_code = (r_phase == PH_PRE_M) ? ERR_MAXVAL : ERR_ZERO;
                end
            end
            PH_IN_W, PH_IN_H: begin
                if (dg) begin
                    n_acc = acc_c;
                end else if (sp || (hash && (r_phase == PH_IN_W || !one_bit))) begin
                    n_acc = '0;
                    if (r_acc == '0) begin
                        fail_req = 1'b1; fail_code = ERR_ZERO;
                    end else if (r_acc > DIM_W'(MAX_DIM)) begin
                        fail_req = 1'b1; fail_code = ERR_LARGE;
                    end else if (r_phase == PH_IN_W) begin
                        n_width = r_acc;  n_phase = PH_PRE_H;  n_cmt = hash;
                    end else begin
                        n_height = r_acc;
                        if (one_bit) hdr_req = 1'b1;
                        else begin n_phase = PH_PRE_M; n_cmt = hash; end
                    end
                end else begin
                    fail_req = 1'b1; fail_code = ERR_ZERO;
                end
            end
            PH_IN_M: begin
                if (dg) n_acc = acc_c;
                else if (sp && r_acc == DIM_W'(255)) hdr_req = 1'b1;
                else begin fail_req = 1'b1; fail_code = ERR_MAXVAL; end
            end
            PH_DATA: begin
                case (r_fmt)
                    FMT_P1: begin
                        if (!sp) begin
                            comp_req = 1'b1;
                            comp_v   = (i_byte_value == CH_ZERO) ? 8'd255 : 8'd0;
                        end
                    end
                    FMT_P2, FMT_P3: begin
                        if (dg) begin n_acc = acc_0; n_phase = PH_DATA_NUM; end
                        else if (!sp) begin fail_req = 1'b1; fail_code = ERR_PIXEL; end
                    end
                    FMT_P4:  pk_req = 1'b1;
                    default: begin comp_req = 1'b1; comp_v = i_byte_value; end
                endcase
            end
            PH_DATA_NUM: begin
                if (dg) n_acc = acc_c;
                else if (sp) begin
                    n_acc = '0;  n_phase = PH_DATA;
                    if (r_acc > DIM_W'(255)) begin fail_req = 1'b1; fail_code = ERR_PIXEL; end
                    else begin comp_req = 1'b1; comp_v = r_acc[7:0]; end
                end else begin
                    fail_req = 1'b1; fail_code = ERR_PIXEL;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // A pending ASCII value is completed by the end of the file.
        if (i_file_end && n_phase == PH_DATA_NUM) begin
            fin_val = n_acc;
            n_acc   = '0;
            n_phase = PH_DATA;
            if (fin_val > DIM_W'(255)) begin fail_req = 1'b1; fail_code = ERR_PIXEL; end
            else begin comp_req = 1'b1; comp_v = fin_val[7:0]; end
        end

        if (hdr_req) begin
            if (r_tc == TGT_BAD) begin
                fail_req = 1'b1; fail_code = ERR_CONV;
            end else begin
                ev_hdr = 1'b1;  n_phase = PH_DATA;
                n_col = '0;  n_row = '0;  n_ci = '0;  n_acc = '0;
            end
        end

        if (comp_req) begin
            ev_pix = 1'b1;  ev_val = comp_v;  ev_ci = r_ci;
            if (!fin) begin
                n_ci = r_ci + 2'd1;
            end else begin
                n_ci = '0;
                if ({1'b0, r_col} + (DIM_W+1)'(1) >= {1'b0, r_width}) begin
                    n_col = '0;
                    n_row = r_row + DIM_W'(1);
                    if ({1'b0, r_row} + (DIM_W+1)'(1) >= {1'b0, r_height}) begin
                        n_phase = PH_DONE;  ev_done = 1'b1;
                    end
                end else begin
                    n_col = r_col + DIM_W'(1);
                end
            end
        end

        // Packed bits: one byte never runs past the end of its row.
        if (pk_req) begin
            ev_pix = 1'b1;  ev_val = i_byte_value;  ev_bits = 1'b1;
            if (rem > DIM_W'(8)) begin
                ev_last = 3'd7;
                n_col   = r_col + DIM_W'(8);
            end else begin
                ev_last = rem[2:0] - 3'd1;
                n_col   = '0;
                n_row   = r_row + DIM_W'(1);
                if ({1'b0, r_row} + (DIM_W+1)'(1) >= {1'b0, r_height}) begin
                    n_phase = PH_DONE;  ev_done = 1'b1;
                end
            end
        end

        if (fail_req) begin
            ev_err = 1'b1;  ev_code = fail_code;  n_phase = PH_DONE;  n_cmt = 1'b0;
        end

        if (i_file_end) begin
            if (n_phase != PH_DONE) begin
                ev_err = 1'b1;  ev_code = ERR_TRUNC;  ev_hdr = 1'b0;  ev_pix = 1'b0;
            end
            n_phase = PH_MAGIC;  n_fmt = '0;  n_width = '0;  n_height = '0;  n_acc = '0;
            n_col = '0;  n_row = '0;  n_ci = '0;  n_cmt = 1'b0;
        end
    end

    always_comb begin
        o_cmd_valid    = accept && (ev_err || ev_hdr || ev_pix);
        o_cmd.kind     = ev_err ? KIND_ERR : (ev_hdr ? KIND_HDR : KIND_PIX);
        o_cmd.value    = ev_val;
        o_cmd.bit_mode = ev_bits;
        o_cmd.last_idx = ev_last;
        o_cmd.ci       = ev_ci;
        o_cmd.fch      = fch;
        o_cmd.och      = och;
        o_cmd.done     = ev_done;
        o_cmd.err      = ev_code;
        o_cmd.width    = n_width;
        o_cmd.height   = n_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;  r_fmt <= '0;  r_width <= '0;  r_height <= '0;
            r_acc <= '0;  r_col <= '0;  r_row <= '0;  r_ci <= '0;  r_cmt <= 1'b0;
            r_tc <= TGT_KEEP;
        end else begin
            if (i_cfg_wr_en) r_tc <= i_cfg_wr_data;
            if (accept) begin
                r_phase <= n_phase;  r_fmt <= n_fmt;  r_width <= n_width;
                r_height <= n_height;  r_acc <= n_acc;  r_col <= n_col;
                r_row <= n_row;  r_ci <= n_ci;  r_cmt <= n_cmt;
            end
        end
    end

endmodule

[hdl/nsd_queue.sv]
`timescale 1ns / 1ps
module nsd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nsd_pkg::t_cmd   i_data,
    output logic            o_full,
    output logic            o_valid,
    output nsd_pkg::t_cmd   o_data,
    input  logic            i_pop
);
    import nsd_pkg::*;

    t_cmd               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QPTR_W:0]    r_cnt;
    logic               do_pop;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;  r_rd <= '0;  r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + QPTR_W'(1);
            if (do_pop) r_rd <= r_rd + QPTR_W'(1);
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push && !o_full) - (QPTR_W+1)'(do_pop);
        end
    end

endmodule

[hdl/nsd_back.sv]
`timescale 1ns / 1ps
module nsd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  nsd_pkg::t_cmd               i_q_data,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_pixel_value,
    output logic [1:0]                  o_component,
    output logic [nsd_pkg::DIM_W-1:0]   o_image_width,
    output logic [nsd_pkg::DIM_W-1:0]   o_image_height,
    output logic [1:0]                  o_out_channels,
    output logic [2:0]                  o_error_code,
    output logic                        o_image_done,
    output logic                        o_run_last
);
    import nsd_pkg::*;

    logic [2:0]     r_j;
    logic [1:0]     r_r;
    logic [9:0]     r_sum;
    logic           r_o_valid;
    logic           is_pix, rep, mean, last_step, emit, go;
    logic [7:0]     comp_v, quot;
    logic [9:0]     sum_tot;
    logic [19:0]    prod;

    assign is_pix  = (i_q_data.kind == KIND_PIX);
    assign rep     = (i_q_data.fch == 2'd1) && (i_q_data.och == 2'd3);
    assign mean    = (i_q_data.fch == 2'd3) && (i_q_data.och == 2'd1);
    // Packed bits go out MSB first; a set bit is black.
    assign comp_v  = i_q_data.bit_mode ? (i_q_data.value[~r_j] ? 8'd0 : 8'd255)
                                       : i_q_data.value;
    assign sum_tot = r_sum + {2'b0, comp_v};
    // Exact sum / 3 for every sum below 768.
    assign prod    = {10'b0, sum_tot} * 20'd683;
    assign quot    = prod[18:11];
    assign last_step = !is_pix ||
                       ((r_j == i_q_data.last_idx) && (!rep || r_r == 2'd2));
    assign emit    = !is_pix || !mean || (i_q_data.ci == 2'd2);
    assign go      = i_q_valid && (!r_o_valid || !i_stall);
    assign o_q_pop = go && last_step;
    assign o_valid = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;  r_j <= '0;  r_r <= '0;  r_sum <= '0;
        end else begin
            if (!r_o_valid || !i_stall) r_o_valid <= go && emit;
            if (go) begin
                if (last_step) begin
                    r_j <= '0;  r_r <= '0;
                end else if (rep && r_r != 2'd2) begin
                    r_r <= r_r + 2'd1;
                end else begin
                    r_r <= '0;  r_j <= r_j + 3'd1;
                end
                if (!is_pix) r_sum <= '0;
                else if (mean) r_sum <= (i_q_data.ci == 2'd2) ? 10'd0 : sum_tot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            o_kind         <= i_q_data.kind;
            o_run_last     <= last_step;
            o_image_width  <= (i_q_data.kind == KIND_HDR) ? i_q_data.width : '0;
            o_image_height <= (i_q_data.kind == KIND_HDR) ? i_q_data.height : '0;
            o_error_code   <= (i_q_data.kind == KIND_ERR) ? i_q_data.err : ERR_NONE;
            o_out_channels <= (i_q_data.kind == KIND_ERR) ? 2'd1 : i_q_data.och;
            o_pixel_value  <= !is_pix ? 8'd0 : (mean ? quot : comp_v);
            o_component    <= !is_pix ? 2'd0 : (rep ? r_r : (mean ? 2'd0 : i_q_data.ci));
            o_image_done   <= is_pix && i_q_data.done && last_step;
        end
    end

endmodule

[hdl/netpbm_stream_decoder.sv]
`timescale 1ns / 1ps
// Netpbm (P1..P6) stream decoder.
// Input channel: one file byte per beat (i_byte_value, i_file_end on the last
// byte), i_valid with o_stall. Output channel: one result per beat, o_valid
// with i_stall; o_run_last marks the last result caused by one input byte.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the target channel
// register; write it only while no file is in flight.
// A front parser takes one byte per cycle while the queue is not full and
// turns it into at most one command, held in a four-entry queue. The back
// end expands each command into its results at one result per cycle while
// i_stall is low: a packed P4 byte gives up to 8 pixels, and grey to RGB
// triples that, so one byte can give up to 24 results. A byte is queued, then
// its first result registered. One-result bytes run at one per cycle unstalled.
// Reset (synchronous, active low) returns the parser to expecting a magic,
// empties the queue, drops any pending result and sets target channels to 0.
// When the receiver stalls, the output beat holds, the queue fills and
// o_stall rises once four commands wait.
module netpbm_stream_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_byte_value,
    input  logic                        i_file_end,
    input  logic                        i_cfg_wr_en,
    input  logic [1:0]                  i_cfg_wr_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_pixel_value,
    output logic [1:0]                  o_component,
    output logic [nsd_pkg::DIM_W-1:0]   o_image_width,
    output logic [nsd_pkg::DIM_W-1:0]   o_image_height,
    output logic [1:0]                  o_out_channels,
    output logic [2:0]                  o_error_code,
    output logic                        o_image_done,
    output logic                        o_run_last
);
    import nsd_pkg::*;

    t_cmd   push_cmd, head_cmd;
    logic   push_valid, q_full, q_valid, q_pop;

    assign o_stall = q_full;

    nsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_byte_value  (i_byte_value),
        .i_file_end    (i_file_end),
        .i_q_full      (q_full),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cmd_valid   (push_valid),
        .o_cmd         (push_cmd)
    );

    nsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_valid),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_cmd),
        .i_pop   (q_pop)
    );

    nsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (head_cmd),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_pixel_value  (o_pixel_value),
        .o_component    (o_component),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_out_channels (o_out_channels),
        .o_error_code   (o_error_code),
        .o_image_done   (o_image_done),
        .o_run_last     (o_run_last)
    );

endmodule

[hdl/nsd_checker.sv]
`timescale 1ns / 1ps
module nsd_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_stall,
    input  logic [7:0]                  i_byte_value,
    input  logic                        i_file_end,
    input  logic                        i_cfg_wr_en,
    input  logic [1:0]                  i_cfg_wr_data,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [1:0]                  o_kind,
    input  logic [7:0]                  o_pixel_value,
    input  logic [1:0]                  o_component,
    input  logic [nsd_pkg::DIM_W-1:0]   o_image_width,
    input  logic [nsd_pkg::DIM_W-1:0]   o_image_height,
    input  logic [1:0]                  o_out_channels,
    input  logic [2:0]                  o_error_code,
    input  logic                        o_image_done,
    input  logic                        o_run_last
);
    import nsd_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_value) && $stable(o_kind))
        else $error("stalled output beat changed");

    a_hdr_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_HDR |-> o_run_last && o_error_code == ERR_NONE)
        else $error("header result not alone");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_ERR |-> o_run_last && o_out_channels == 2'd1)
        else $error("error result malformed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_image_done |-> o_run_last && o_kind == KIND_PIX)
        else $error("image end not on last pixel result");

endmodule

bind netpbm_stream_decoder nsd_checker u_nsd_checker (.*);
